// ===== sv/nms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nms_pkg: shared types and constants of the neighbour mean smoothing block
// Sample, sum and result widths, register indexes and the bundles that travel
// between the window cells, the slot register and the mean pipeline.
// ----------------------------------------------------------------------------
package nms_pkg;

  // Field widths of the ports.
  localparam int SAMPLE_BITS = 16;
  localparam int ROWS_CFG_W  = 13;
  localparam int COLS_CFG_W  = 11;
  localparam int CFG_W       = 13;
  localparam int ROW_OUT_W   = 12;
  localparam int COL_OUT_W   = 10;
  localparam int MEAN_W      = 24;

  // Default frame limits.
  localparam int DEF_MAX_COLS = 1024;
  localparam int DEF_MAX_ROWS = 4096;

  // A sum of up to four samples, and the Q8 magnitude of the mean.
  localparam int SUM_W     = SAMPLE_BITS + 2;
  localparam int FRAC_BITS = 8;
  localparam int QMAG_W    = SUM_W + FRAC_BITS - 1;

  typedef enum logic [0:0] {
    REG_FRAME_ROWS = 1'b0,
    REG_FRAME_COLS = 1'b1
  } reg_idx_t;

  // Number of neighbours that enter a mean.
  typedef enum logic [1:0] {
    CNT_TWO,
    CNT_THREE,
    CNT_FOUR
  } cnt_t;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // One window cell: a tap of the previous row and a tap of the current row.
  typedef struct packed {
    sample_t prev;
    sample_t cur;
  } tap_t;

  typedef struct packed {
    logic [ROW_OUT_W-1:0] row;
    logic [COL_OUT_W-1:0] col;
    logic                 last;
  } tag_t;

  // One pending result: neighbour sum, neighbour count and position.
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    cnt_t                    cnt;
    tag_t                    tag;
  } slot_t;

endpackage

// ===== sv/nms_line_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nms_line_ram: one line buffer
// Single write port and single read port with a registered read. A read of
// the address written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
module nms_line_ram #(
  parameter  int DEPTH  = nms_pkg::DEF_MAX_COLS,
  parameter  int DATA_W = nms_pkg::SAMPLE_BITS,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              en,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // Write, and read with write-through on an address match.
  always_ff @(posedge clk) begin
    if (en) begin
      mem[waddr] <= wdata;
      if (raddr == waddr) begin
        rdata_r <= wdata;
      end else begin
        rdata_r <= mem[raddr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/nms_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nms_cell: one window cell
// Holds a previous-row tap and a current-row tap and passes them on to the
// next cell on every accepted beat. The flag tells whether the current-row
// tap belongs to the row now arriving; it drops at the end of each row.
// ----------------------------------------------------------------------------
module nms_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          clear,
  input  logic          shift,
  input  logic          row_end,
  input  nms_pkg::tap_t tap_in,
  input  logic          flag_in,
  output nms_pkg::tap_t tap_out,
  output logic          flag_out
);
  import nms_pkg::*;

  tap_t tap_r;
  logic flag_r;
  logic flag_nxt;

  // The flag survives a shift only inside a row.
  always_comb begin
    flag_nxt = flag_r;
    if (clear) begin
      flag_nxt = 1'b0;
    end else if (shift) begin
      flag_nxt = flag_in && !row_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r <= 1'b0;
    end else begin
      flag_r <= flag_nxt;
    end
  end

  // Tap data needs no reset.
  always_ff @(posedge clk) begin
    if (shift) begin
      tap_r <= tap_in;
    end
  end

  assign tap_out  = tap_r;
  assign flag_out = flag_r;

endmodule

// ===== sv/nms_mean.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nms_mean: neighbour mean pipeline
// Turns a neighbour sum and count into a Q8 mean rounded to nearest, in three
// register stages: magnitude, scaling or division by three, sign and
// saturation into the output register. The whole pipeline holds on a stall.
// ----------------------------------------------------------------------------
module nms_mean (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               slot_valid,
  input  nms_pkg::slot_t                     slot_in,
  output logic                               pipe_ready,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [nms_pkg::MEAN_W-1:0]  out_mean_value,
  output logic [nms_pkg::ROW_OUT_W-1:0]      out_row,
  output logic [nms_pkg::COL_OUT_W-1:0]      out_col,
  output logic                               out_frame_end
);
  import nms_pkg::*;

  // Division by three as a multiplication by a rounded-up reciprocal. The
  // dividend stays below 2**M_W, so one extra shift bit makes it exact.
  localparam int M_W         = SUM_W + FRAC_BITS;
  localparam int RECIP_SHIFT = M_W + 1;
  localparam int RECIP_W     = M_W;
  localparam int PROD_W      = M_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** RECIP_SHIFT + 2) / 3);
  localparam logic signed [QMAG_W:0] SAT_HI = (QMAG_W + 1)'(2 ** (MEAN_W - 1) - 1);
  localparam logic signed [QMAG_W:0] SAT_LO = (QMAG_W + 1)'(-(2 ** (MEAN_W - 1)));

  logic              a_vld_r;
  logic              a_neg_r;
  cnt_t              a_cnt_r;
  logic [SUM_W-1:0]  a_mag_r;
  tag_t              a_tag_r;
  logic              b_vld_r;
  logic              b_neg_r;
  logic [QMAG_W-1:0] b_qmag_r;
  tag_t              b_tag_r;
  logic              out_valid_r;
  logic signed [MEAN_W-1:0] out_mean_r;
  tag_t              out_tag_r;

  logic [SUM_W-1:0]  mag_in;
  logic [M_W-1:0]    m3;
  logic [PROD_W-1:0] prod;
  logic [QMAG_W-1:0] qmag_nxt;
  logic signed [QMAG_W:0]   qs;
  logic signed [MEAN_W-1:0] mean_nxt;

  assign pipe_ready = !out_valid_r || !out_stall;

  // Stage A: magnitude of the sum.
  assign mag_in = slot_in.sum[SUM_W-1] ? SUM_W'(-slot_in.sum) : SUM_W'(slot_in.sum);

  // Stage B: scale by 256 and divide by the count, rounding half away from zero.
  assign m3   = {a_mag_r, {FRAC_BITS{1'b0}}} + M_W'(1);
  assign prod = m3 * RECIP;

  always_comb begin
    unique case (a_cnt_r)
      CNT_TWO:   qmag_nxt = QMAG_W'(a_mag_r) << (FRAC_BITS - 1);
      CNT_THREE: qmag_nxt = prod[PROD_W-1:RECIP_SHIFT];
      CNT_FOUR:  qmag_nxt = QMAG_W'(a_mag_r) << (FRAC_BITS - 2);
      default:   qmag_nxt = '0;
    endcase
  end

  // Output stage: restore the sign and saturate to the result width.
  assign qs = b_neg_r ? -$signed({1'b0, b_qmag_r}) : $signed({1'b0, b_qmag_r});

  always_comb begin
    if (qs > SAT_HI) begin
      mean_nxt = MEAN_W'(SAT_HI);
    end else if (qs < SAT_LO) begin
      mean_nxt = MEAN_W'(SAT_LO);
    end else begin
      mean_nxt = MEAN_W'(qs);
    end
  end

  // Valid bits of the stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r     <= 1'b0;
      b_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (pipe_ready) begin
      a_vld_r     <= slot_valid;
      b_vld_r     <= a_vld_r;
      out_valid_r <= b_vld_r;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (pipe_ready) begin
      a_neg_r    <= slot_in.sum[SUM_W-1];
      a_cnt_r    <= slot_in.cnt;
      a_mag_r    <= mag_in;
      a_tag_r    <= slot_in.tag;
      b_neg_r    <= a_neg_r;
      b_qmag_r   <= qmag_nxt;
      b_tag_r    <= a_tag_r;
      out_mean_r <= mean_nxt;
      out_tag_r  <= b_tag_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_mean_value = out_mean_r;
  assign out_row        = out_tag_r.row;
  assign out_col        = out_tag_r.col;
  assign out_frame_end  = out_tag_r.last;

endmodule

// ===== sv/neighbour_mean_smoothing.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbour_mean_smoothing: four-neighbour mean filter over a raster frame
// Samples arrive in row-major order; each result is the mean of the up, down,
// left and right neighbours inside the frame, in Q8, one row behind the input.
//
//   channel   direction   handshake            payload
//   in_       input       in_valid/in_stall    in_sample
//   out_      output      out_valid/out_stall  out_mean_value out_row out_col
//                                              out_frame_end
//   cfg_      input       cfg_we               cfg_index cfg_wdata
//
// Rows 0 to rows-2 take one sample per cycle, set by the slot register that
// hands one result per cycle to the mean pipeline; on the last row a sample
// gives one result on the first column, two in between and three on the final
// one; the input stalls while more than one waits in the slot register.
// Results pass the slot register, mean stages A and B and the output register.
// Reset and any register write restart the frame at element (0, 0); the line
// buffers need no clearing pass, as every entry is written before it is read.
// out_stall holds the mean pipeline; input beats go on while the slot register
// can be emptied.
// ----------------------------------------------------------------------------
module neighbour_mean_smoothing #(
  parameter int MAX_COLS = nms_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = nms_pkg::DEF_MAX_ROWS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  nms_pkg::reg_idx_t                     cfg_index,
  input  logic [nms_pkg::CFG_W-1:0]             cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [nms_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [nms_pkg::MEAN_W-1:0]     out_mean_value,
  output logic [nms_pkg::ROW_OUT_W-1:0]         out_row,
  output logic [nms_pkg::COL_OUT_W-1:0]         out_col,
  output logic                                  out_frame_end
);
  import nms_pkg::*;

  localparam int COL_W = $clog2(MAX_COLS);
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int CELLS = 2;
  localparam int SLOTS = 3;

  // Count of extra neighbours beyond the first one, as a count code.
  function automatic cnt_t count_code(input logic [1:0] extra);
    cnt_t code;
    unique case (extra)
      2'd2:    code = CNT_THREE;
      2'd3:    code = CNT_FOUR;
      default: code = CNT_TWO;
    endcase
    return code;
  endfunction

  logic [ROW_W-1:0] rows_last_r, rows_last_nxt;
  logic [COL_W-1:0] cols_last_r, cols_last_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROWS_CFG_W-1:0] rows_wr;
  logic [COLS_CFG_W-1:0] cols_wr;
  logic restart;
  logic in_acc;
  logic last_row;
  logic last_col;

  logic [COL_W-1:0] raddr_newer;
  logic [COL_W-1:0] raddr_older;
  logic [SAMPLE_BITS-1:0] newer_rd;
  logic [SAMPLE_BITS-1:0] older_rd;

  tap_t tap_chain  [CELLS+1];
  logic flag_chain [CELLS+1];

  sample_t x, up, right, mid, left, x1, x2;
  logic    hu, hl, hr, has_c2;
  slot_t   new_slot [SLOTS];
  logic [SLOTS-1:0] new_vld;

  slot_t g_slot_r [SLOTS];
  logic [SLOTS-1:0] g_vld_r, g_vld_nxt;
  logic [SLOTS-1:0] issue_mask;
  slot_t issue_slot;
  logic  issue_valid;
  logic  g_multi;
  logic  pipe_ready;

  assign restart  = cfg_we;
  assign in_acc   = in_valid && !in_stall;
  assign last_row = (row_r == rows_last_r);
  assign last_col = (col_r == cols_last_r);

  // Register writes, with out-of-range values pulled into the frame limits.
  always_comb begin
    rows_wr       = cfg_wdata[ROWS_CFG_W-1:0];
    cols_wr       = cfg_wdata[COLS_CFG_W-1:0];
    rows_last_nxt = rows_last_r;
    cols_last_nxt = cols_last_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_ROWS: begin
          if (rows_wr < ROWS_CFG_W'(2)) begin
            rows_last_nxt = ROW_W'(1);
          end else if (32'(rows_wr) > MAX_ROWS) begin
            rows_last_nxt = ROW_W'(MAX_ROWS - 1);
          end else begin
            rows_last_nxt = ROW_W'(rows_wr - ROWS_CFG_W'(1));
          end
        end
        REG_FRAME_COLS: begin
          if (cols_wr < COLS_CFG_W'(2)) begin
            cols_last_nxt = COL_W'(1);
          end else if (32'(cols_wr) > MAX_COLS) begin
            cols_last_nxt = COL_W'(MAX_COLS - 1);
          end else begin
            cols_last_nxt = COL_W'(cols_wr - COLS_CFG_W'(1));
          end
        end
      endcase
    end
  end

  // Position of the next sample; wraps to (0, 0) after the last element.
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (restart) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (in_acc) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : ROW_W'(row_r + 1'b1);
      end else begin
        col_nxt = COL_W'(col_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_last_r <= ROW_W'(1);
      cols_last_r <= COL_W'(1);
      row_r       <= '0;
      col_r       <= '0;
    end else begin
      rows_last_r <= rows_last_nxt;
      cols_last_r <= cols_last_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
    end
  end

  // Read addresses run ahead: the older line one column, the newer line two,
  // both wrapping into the next row.
  always_comb begin
    raddr_older = last_col ? '0 : COL_W'(col_r + 1'b1);
    if (last_col) begin
      raddr_newer = COL_W'(1);
    end else if (col_r == COL_W'(cols_last_r - 1'b1)) begin
      raddr_newer = '0;
    end else begin
      raddr_newer = COL_W'(col_r + 2'd2);
    end
  end

  // Newer line holds row r-1 ahead of the current column and row r behind it.
  nms_line_ram #(
    .DEPTH  (MAX_COLS),
    .DATA_W (SAMPLE_BITS)
  ) u_line_newer (
    .clk   (clk),
    .en    (in_acc),
    .waddr (col_r),
    .wdata (in_sample),
    .raddr (raddr_newer),
    .rdata (newer_rd)
  );

  // Older line takes over row r-1 column by column.
  nms_line_ram #(
    .DEPTH  (MAX_COLS),
    .DATA_W (SAMPLE_BITS)
  ) u_line_older (
    .clk   (clk),
    .en    (in_acc),
    .waddr (col_r),
    .wdata (tap_chain[1].prev),
    .raddr (raddr_older),
    .rdata (older_rd)
  );

  // Window cells: previous-row taps from the newer line, current-row taps
  // from the input stream.
  assign tap_chain[0]  = '{prev: $signed(newer_rd), cur: in_sample};
  assign flag_chain[0] = 1'b1;

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    nms_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .clear    (restart),
      .shift    (in_acc),
      .row_end  (last_col),
      .tap_in   (tap_chain[k]),
      .flag_in  (flag_chain[k]),
      .tap_out  (tap_chain[k+1]),
      .flag_out (flag_chain[k+1])
    );
  end

  // Neighbours of the results released by this beat.
  always_comb begin
    x      = in_sample;
    up     = $signed(older_rd);
    right  = $signed(newer_rd);
    mid    = tap_chain[1].prev;
    x1     = tap_chain[1].cur;
    left   = tap_chain[2].prev;
    x2     = tap_chain[2].cur;
    hu     = (row_r > ROW_W'(1));
    hl     = flag_chain[1];
    hr     = !last_col;
    has_c2 = flag_chain[2];

    // Element one row up at this column.
    new_vld[0]          = (row_r != '0);
    new_slot[0].sum     = SUM_W'(x) + (hu ? SUM_W'(up) : '0) + (hl ? SUM_W'(left) : '0)
                          + (hr ? SUM_W'(right) : '0);
    new_slot[0].cnt     = count_code({1'b0, hu} + {1'b0, hl} + {1'b0, hr});
    new_slot[0].tag.row = ROW_OUT_W'(ROW_W'(row_r - 1'b1));
    new_slot[0].tag.col = COL_OUT_W'(col_r);
    new_slot[0].tag.last = 1'b0;

    // Last row, element one column to the left.
    new_vld[1]          = last_row && hl;
    new_slot[1].sum     = SUM_W'(left) + SUM_W'(x) + (has_c2 ? SUM_W'(x2) : '0);
    new_slot[1].cnt     = count_code({1'b0, has_c2} + 2'd1);
    new_slot[1].tag.row = ROW_OUT_W'(row_r);
    new_slot[1].tag.col = COL_OUT_W'(COL_W'(col_r - 1'b1));
    new_slot[1].tag.last = 1'b0;

    // Last row, final element of the frame.
    new_vld[2]          = last_row && last_col;
    new_slot[2].sum     = SUM_W'(mid) + SUM_W'(x1);
    new_slot[2].cnt     = CNT_TWO;
    new_slot[2].tag.row = ROW_OUT_W'(row_r);
    new_slot[2].tag.col = COL_OUT_W'(col_r);
    new_slot[2].tag.last = 1'b1;
  end

  // Slot register: results of one beat, handed on lowest slot first.
  always_comb begin
    issue_slot = g_slot_r[0];
    issue_mask = '0;
    if (g_vld_r[0]) begin
      issue_slot = g_slot_r[0];
      issue_mask = 3'b001;
    end else if (g_vld_r[1]) begin
      issue_slot = g_slot_r[1];
      issue_mask = 3'b010;
    end else if (g_vld_r[2]) begin
      issue_slot = g_slot_r[2];
      issue_mask = 3'b100;
    end
  end

  assign issue_valid = |g_vld_r;
  assign g_multi     = (g_vld_r[0] && g_vld_r[1]) || (g_vld_r[0] && g_vld_r[2])
                       || (g_vld_r[1] && g_vld_r[2]);
  assign in_stall    = g_multi || (issue_valid && !pipe_ready);

  always_comb begin
    g_vld_nxt = g_vld_r;
    if (in_acc) begin
      g_vld_nxt = new_vld;
    end else if (pipe_ready) begin
      g_vld_nxt = g_vld_r & ~issue_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_vld_r <= '0;
    end else begin
      g_vld_r <= g_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int k = 0; k < SLOTS; k++) begin
        g_slot_r[k] <= new_slot[k];
      end
    end
  end

  // Mean pipeline and output register.
  nms_mean u_mean (
    .clk            (clk),
    .rst_n          (rst_n),
    .slot_valid     (issue_valid),
    .slot_in        (issue_slot),
    .pipe_ready     (pipe_ready),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_mean_value (out_mean_value),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_frame_end  (out_frame_end)
  );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the neighbour mean smoothing block
// Streams frames of signed samples through the block under several frame
// sizes, predicts every neighbour mean with its own line buffers and compares
// each result beat field by field, with random gaps on both channels.
// ----------------------------------------------------------------------------

// One smoothed element as it leaves the block.
typedef struct {
  logic signed [nms_pkg::MEAN_W-1:0] mean_value;
  logic [nms_pkg::ROW_OUT_W-1:0]     row;
  logic [nms_pkg::COL_OUT_W-1:0]     col;
  logic                              frame_end;
} smoothed_t;

// Predicts the neighbour means of the accepted samples and checks the
// result beats against them in order.
class smoothing_scoreboard;
  nms_pkg::sample_t older_line [nms_pkg::DEF_MAX_COLS];
  nms_pkg::sample_t newer_line [nms_pkg::DEF_MAX_COLS];
  nms_pkg::sample_t left_tap;
  int unsigned      row_pos;
  int unsigned      col_pos;
  int unsigned      n_rows;
  int unsigned      n_cols;
  smoothed_t        expected_q[$];
  int unsigned      errors;
  int unsigned      results_seen;

  function new();
    foreach (older_line[k]) begin
      older_line[k] = '0;
      newer_line[k] = '0;
    end
    left_tap     = '0;
    row_pos      = 0;
    col_pos      = 0;
    n_rows       = 2;
    n_cols       = 2;
    errors       = 0;
    results_seen = 0;
  endfunction

  // Register write: clamp into the legal range and restart the frame.
  function void write_reg(nms_pkg::reg_idx_t idx, logic [nms_pkg::CFG_W-1:0] val);
    int unsigned v;
    if (idx == nms_pkg::REG_FRAME_ROWS) begin
      v = val;
      if (v < 2) v = 2;
      if (v > nms_pkg::DEF_MAX_ROWS) v = nms_pkg::DEF_MAX_ROWS;
      n_rows = v;
    end else begin
      v = val[nms_pkg::COLS_CFG_W-1:0];
      if (v < 2) v = 2;
      if (v > nms_pkg::DEF_MAX_COLS) v = nms_pkg::DEF_MAX_COLS;
      n_cols = v;
    end
    row_pos  = 0;
    col_pos  = 0;
    left_tap = '0;
  endfunction

  // Mean in Q8, rounded to nearest with ties away from zero, saturated.
  function logic signed [nms_pkg::MEAN_W-1:0] q8_mean(longint sum, int cnt);
    longint num;
    longint q;
    num = sum * 256;
    if (num >= 0) q = (num + cnt / 2) / cnt;
    else q = -((-num + cnt / 2) / cnt);
    if (q > 64'sd8388607) q = 64'sd8388607;
    if (q < -64'sd8388608) q = -64'sd8388608;
    return q[nms_pkg::MEAN_W-1:0];
  endfunction

  function void queue_result(int unsigned r, int unsigned c, longint sum, int cnt,
                             bit last);
    smoothed_t e;
    e.mean_value = q8_mean(sum, cnt);
    e.row        = r[nms_pkg::ROW_OUT_W-1:0];
    e.col        = c[nms_pkg::COL_OUT_W-1:0];
    e.frame_end  = last;
    expected_q.push_back(e);
  endfunction

  // Accepted sample: update the line buffers and queue the released means.
  function void note_sample(nms_pkg::sample_t x);
    int unsigned      r;
    int unsigned      c;
    bit               last_row;
    bit               last_col;
    nms_pkg::sample_t up;
    nms_pkg::sample_t mid;
    nms_pkg::sample_t right;
    longint           sum;
    int               cnt;
    r        = row_pos;
    c        = col_pos;
    last_row = (r == n_rows - 1);
    last_col = (c == n_cols - 1);
    up       = older_line[c];
    mid      = newer_line[c];
    right    = '0;
    if (!last_col) right = newer_line[c + 1];

    // The element one row up is complete once its lower neighbour arrives.
    if (r >= 1) begin
      sum = x;
      cnt = 1;
      if (r > 1) begin
        sum += up;
        cnt++;
      end
      if (c > 0) begin
        sum += left_tap;
        cnt++;
      end
      if (!last_col) begin
        sum += right;
        cnt++;
      end
      queue_result(r - 1, c, sum, cnt, 1'b0);
    end

    older_line[c] = mid;
    newer_line[c] = x;
    left_tap      = mid;

    // The last row has no lower neighbours and is flushed as it arrives.
    if (last_row) begin
      if (c >= 1) begin
        sum = longint'(older_line[c - 1]) + longint'(x);
        cnt = 2;
        if (c >= 2) begin
          sum += newer_line[c - 2];
          cnt++;
        end
        queue_result(r, c - 1, sum, cnt, 1'b0);
      end
      if (last_col) begin
        sum = longint'(older_line[c]) + longint'(newer_line[c - 1]);
        queue_result(r, c, sum, 2, 1'b1);
      end
    end

    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  function void compare_field(string name, logic signed [63:0] want,
                              logic signed [63:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= 40)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Result beat: compare with the oldest expectation.
  function void check_result(logic signed [nms_pkg::MEAN_W-1:0] mean_value,
                             logic [nms_pkg::ROW_OUT_W-1:0] row,
                             logic [nms_pkg::COL_OUT_W-1:0] col,
                             logic frame_end);
    smoothed_t want;
    results_seen++;
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= 40)
        $display("%0t: unexpected result, expected none, actual row %0d col %0d mean %0d",
                 $time, row, col, mean_value);
      return;
    end
    want = expected_q.pop_front();
    compare_field("mean_value", want.mean_value, mean_value);
    compare_field("out_row", want.row, row);
    compare_field("out_col", want.col, col);
    compare_field("frame_end", want.frame_end, frame_end);
  endfunction
endclass

module tb_top;
  import nms_pkg::*;

  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_ITEMS  = 380;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  reg_idx_t                cfg_index = REG_FRAME_ROWS;
  logic [CFG_W-1:0]        cfg_wdata = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  sample_t                 in_sample = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [MEAN_W-1:0] out_mean_value;
  logic [ROW_OUT_W-1:0]    out_row;
  logic [COL_OUT_W-1:0]    out_col;
  logic                    out_frame_end;

  // Gaps and stalls are switched off together for a calm stretch.
  bit                      gaps_on = 1'b1;
  int unsigned             beats_sent = 0;
  int unsigned             settings_count = 0;

  smoothing_scoreboard smoother = new();

  neighbour_mean_smoothing DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample     (in_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_mean_value(out_mean_value),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_frame_end (out_frame_end)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: check each accepted beat, then pick the next stall.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      smoother.check_result(out_mean_value, out_row, out_col, out_frame_end);
    out_stall <= gaps_on && ($urandom_range(99) < 33);
  end

  // Send one sample beat, with a random gap in front of it.
  task automatic send_sample(input sample_t s);
    if (gaps_on) begin
      while ($urandom_range(99) < 33) begin
        in_valid  <= 1'b0;
        in_sample <= sample_t'($urandom);
        @(posedge clk);
      end
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    smoother.note_sample(s);
    beats_sent++;
  endtask

  task automatic send_list(input sample_t vals[$]);
    foreach (vals[k]) send_sample(vals[k]);
  endtask

  // Hold the input until every expected result is out, then let the
  // pipeline settle, since row-0 beats produce nothing to wait for.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (smoother.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    smoother.write_reg(idx, val);
    settings_count++;
  endtask

  // Mostly full-range samples, with extremes and small values mixed in.
  function automatic sample_t rand_sample();
    case ($urandom_range(7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return sample_t'($urandom_range(8)) - 16'sd4;
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic send_random(input int unsigned count);
    for (int unsigned k = 0; k < count; k++) send_sample(rand_sample());
  endtask

  initial begin
    int unsigned random_sent;
    int unsigned phase_no;
    int unsigned phase_items;
    int unsigned frame_size;
    int unsigned drain_at;
    logic [CFG_W-1:0] rows_w;
    logic [CFG_W-1:0] cols_w;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset size 2x2 with extreme samples, twice to cross the wrap.
    send_list('{16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF});
    send_list('{-16'sd1, 16'sd1, 16'sh8000, 16'sh7FFE});

    // 3x3: corners, edges and the interior.
    write_reg(REG_FRAME_ROWS, 13'd3);
    write_reg(REG_FRAME_COLS, 13'd3);
    send_list('{16'sh7FFF, 16'sh8000, 16'sh7FFF,
                16'sh8000, 16'sh7FFF, 16'sh8000,
                -16'sd1, 16'sd1, -16'sd3});

    // Values below the minimum are taken as 2.
    write_reg(REG_FRAME_ROWS, 13'd0);
    write_reg(REG_FRAME_COLS, 13'd1);
    send_list('{16'sd0, -16'sd1, -16'sd2, 16'sd5});

    // Random frames of small sizes, often cut short by a new setting.
    random_sent = 0;
    phase_no    = 0;
    while (random_sent < RANDOM_ITEMS) begin
      gaps_on <= !(random_sent >= 150 && random_sent < 260);
      case ($urandom_range(9))
        0:       rows_w = CFG_W'($urandom_range(1));
        default: rows_w = CFG_W'($urandom_range(2, 6));
      endcase
      case ($urandom_range(9))
        0:       cols_w = CFG_W'($urandom_range(1));
        1:       cols_w = 13'h1800 | CFG_W'($urandom_range(2, 9));
        default: cols_w = CFG_W'($urandom_range(2, 10));
      endcase
      case ($urandom_range(2))
        0: begin
          write_reg(REG_FRAME_ROWS, rows_w);
          write_reg(REG_FRAME_COLS, cols_w);
        end
        1:       write_reg(REG_FRAME_ROWS, rows_w);
        default: write_reg(REG_FRAME_COLS, cols_w);
      endcase
      frame_size  = smoother.n_rows * smoother.n_cols;
      phase_items = frame_size * $urandom_range(1, 2);
      if ($urandom_range(2) == 0) phase_items += $urandom_range(frame_size - 1);
      drain_at = 0;
      if (phase_no == 0 || $urandom_range(2) == 0)
        drain_at = $urandom_range(1, phase_items - 1);
      for (int unsigned k = 0; k < phase_items; k++) begin
        if (k == drain_at && drain_at != 0) drain_results();
        send_sample(rand_sample());
      end
      random_sent += phase_items;
      phase_no++;
    end
    gaps_on <= 1'b1;

    // Row count above the maximum: the first rows of a frame two columns wide.
    write_reg(REG_FRAME_ROWS, 13'h1FFF);
    write_reg(REG_FRAME_COLS, 13'd0);
    send_random(40);

    // Column count above the maximum: the start of a wide first row.
    write_reg(REG_FRAME_ROWS, 13'd2);
    write_reg(REG_FRAME_COLS, 13'h1FFF);
    send_random(30);

    drain_results();
    if (smoother.expected_q.size() != 0) begin
      smoother.errors += smoother.expected_q.size();
      $display("%0t: %0d results expected but never seen", $time,
               smoother.expected_q.size());
    end

    $display("Sent %0d sample beats over %0d register settings, checked %0d results.",
             beats_sent, settings_count, smoother.results_seen);
    $display("Mismatches found: %0d", smoother.errors);
    if (smoother.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #10ms;
    $display("Timeout with %0d results still expected", smoother.expected_q.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
